// ===== rtl/csqt_pkg.sv =====
// Types and constants shared by the cosine-squared taper blocks.
// Depends on nothing.
`timescale 1ns / 1ps

package csqt_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 24;
    localparam int WGT_W = 17;
    localparam int POS_W = 11;
    localparam int A_W   = 30;
    localparam int S2_W  = 29;
    localparam int P_W   = 36;

    localparam int MAX_LENGTH = 1024;

    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_RAMP = 2'd2;

    localparam logic [2:0] REG_UP_START   = 3'd0;
    localparam logic [2:0] REG_UP_END     = 3'd1;
    localparam logic [2:0] REG_DOWN_START = 3'd2;
    localparam logic [2:0] REG_DOWN_END   = 3'd3;
    localparam logic [2:0] REG_ACCUMULATE = 3'd4;

    // sine polynomial coefficients, signed Q6.30
    localparam logic signed [P_W-1:0] K1  = 36'sd3373259426;
    localparam logic signed [P_W-1:0] K3  = 36'sd5548789346;
    localparam logic signed [P_W-1:0] K5  = 36'sd2738217788;
    localparam logic signed [P_W-1:0] K7  = 36'sd643455389;
    localparam logic signed [P_W-1:0] K9  = 36'sd88203474;
    localparam logic signed [P_W-1:0] K11 = 36'sd7913929;

    typedef struct packed {
        logic [IDX_W-1:0]        sample_index;
        logic signed [VAL_W-1:0] sample_value;
        logic signed [VAL_W-1:0] prior_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [WGT_W-1:0]        weight_applied;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] up_start;
        logic [POS_W-1:0] up_end;
        logic [POS_W-1:0] down_start;
        logic [POS_W-1:0] down_end;
        logic             accumulate;
    } t_cfg;

    // travels alongside each item through the weight pipeline
    typedef struct packed {
        logic signed [VAL_W-1:0] sample;
        logic signed [VAL_W-1:0] prior;
        logic [1:0]              kind;
        logic                    neg;
        logic [A_W-1:0]          a;
        logic [S2_W-1:0]         s2;
    } t_side;

endpackage

// ===== rtl/csqt_regs.sv =====
// APB register file for the taper ramps and accumulate mode.
// Depends on csqt_pkg.
`timescale 1ns / 1ps

module csqt_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output csqt_pkg::t_cfg      o_cfg
);

    csqt_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_start   <= 11'd0;
            r_cfg.up_end     <= 11'd0;
            r_cfg.down_start <= 11'd1024;
            r_cfg.down_end   <= 11'd1024;
            r_cfg.accumulate <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                csqt_pkg::REG_UP_START:   r_cfg.up_start   <= pwdata[10:0];
                csqt_pkg::REG_UP_END:     r_cfg.up_end     <= pwdata[10:0];
                csqt_pkg::REG_DOWN_START: r_cfg.down_start <= pwdata[10:0];
                csqt_pkg::REG_DOWN_END:   r_cfg.down_end   <= pwdata[10:0];
                csqt_pkg::REG_ACCUMULATE: r_cfg.accumulate <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            csqt_pkg::REG_UP_START:   prdata = {21'd0, r_cfg.up_start};
            csqt_pkg::REG_UP_END:     prdata = {21'd0, r_cfg.up_end};
            csqt_pkg::REG_DOWN_START: prdata = {21'd0, r_cfg.down_start};
            csqt_pkg::REG_DOWN_END:   prdata = {21'd0, r_cfg.down_end};
            csqt_pkg::REG_ACCUMULATE: prdata = {31'd0, r_cfg.accumulate};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/csqt_decode.sv =====
// Region decode: picks zero, one or ramp and forms the ramp distance.
// Depends on csqt_pkg.
`timescale 1ns / 1ps

module csqt_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  csqt_pkg::t_in_item  i_item,
    input  csqt_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output csqt_pkg::t_side     o_side,
    output logic [10:0]         o_mag,
    output logic [10:0]         o_den
);

    logic [10:0]        idx;
    logic [10:0]        num;
    logic [10:0]        den;
    logic [1:0]         kind;
    logic signed [12:0] diff;
    logic [12:0]        mag13;
    logic [10:0]        mag;
    csqt_pkg::t_side    n_side;

    logic               r_valid;
    csqt_pkg::t_side    r_side;
    logic [10:0]        r_mag;
    logic [10:0]        r_den;

    assign idx = {1'b0, i_item.sample_index};

    always_comb begin
        num  = 11'd0;
        den  = 11'd1;
        kind = csqt_pkg::KIND_ZERO;
        priority if (idx >= 11'(csqt_pkg::MAX_LENGTH) || idx >= i_cfg.down_end) begin
            kind = csqt_pkg::KIND_ZERO;
        end else if (idx >= i_cfg.down_start) begin
            kind = csqt_pkg::KIND_RAMP;
            num  = idx - i_cfg.down_start;
            den  = i_cfg.down_end - i_cfg.down_start;
        end else if (idx >= i_cfg.up_end) begin
            kind = csqt_pkg::KIND_ONE;
        end else if (idx >= i_cfg.up_start) begin
            kind = csqt_pkg::KIND_RAMP;
            num  = i_cfg.up_end - idx;
            den  = i_cfg.up_end - i_cfg.up_start;
        end else begin
            kind = csqt_pkg::KIND_ZERO;
        end
    end

    // |2*num - den|, clamped to den
    assign diff  = $signed({1'b0, num, 1'b0}) - $signed({2'b00, den});
    assign mag13 = diff[12] ? 13'(-diff) : 13'(diff);
    assign mag   = (mag13 > {2'b00, den}) ? den : mag13[10:0];

    always_comb begin
        n_side        = '0;
        n_side.sample = i_item.sample_value;
        n_side.prior  = i_item.prior_value;
        n_side.kind   = kind;
        n_side.neg    = diff[12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
        r_mag  <= mag;
        r_den  <= den;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_mag   = r_mag;
    assign o_den   = r_den;

endmodule

// ===== rtl/csqt_div.sv =====
// Pipelined restoring divider for the ramp position |x-1/2| in Q0.30,
// eight quotient bits a stage, followed by the squaring stage.
// Depends on csqt_pkg.
`timescale 1ns / 1ps

module csqt_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  csqt_pkg::t_side     i_side,
    input  logic [10:0]         i_mag,
    input  logic [10:0]         i_den,
    output logic                o_valid,
    output csqt_pkg::t_side     o_side
);

    localparam int NST = 5;
    localparam int BPS = 8;

    logic              s_vld  [0:NST];
    logic [10:0]       s_rem  [0:NST];
    logic [39:0]       s_dvd  [0:NST];
    logic [29:0]       s_quo  [0:NST];
    logic [10:0]       s_den  [0:NST];
    csqt_pkg::t_side   s_side [0:NST];

    logic              r_vld  [1:NST];
    logic [10:0]       r_rem  [1:NST];
    logic [39:0]       r_dvd  [1:NST];
    logic [29:0]       r_quo  [1:NST];
    logic [10:0]       r_den  [1:NST];
    csqt_pkg::t_side   r_side [1:NST];

    logic              r_sq_vld;
    csqt_pkg::t_side   r_sq_side;
    csqt_pkg::t_side   n_sq_side;
    logic [59:0]       sq;

    // dividend = mag * 2^29 + den/2
    assign s_vld[0]  = i_valid;
    assign s_rem[0]  = 11'd0;
    assign s_dvd[0]  = {i_mag, 19'd0, i_den[10:1]};
    assign s_quo[0]  = 30'd0;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_stage
            logic [10:0] n_rem;
            logic [39:0] n_dvd;
            logic [29:0] n_quo;

            always_comb begin : p_step
                logic [11:0] rem12;
                n_rem = s_rem[k];
                n_dvd = s_dvd[k];
                n_quo = s_quo[k];
                for (int b = 0; b < BPS; b++) begin
                    rem12 = {n_rem, n_dvd[39]};
                    n_dvd = {n_dvd[38:0], 1'b0};
                    if (rem12 >= {1'b0, s_den[k]}) begin
                        rem12 = rem12 - {1'b0, s_den[k]};
                        n_quo = {n_quo[28:0], 1'b1};
                    end else begin
                        n_quo = {n_quo[28:0], 1'b0};
                    end
                    n_rem = rem12[10:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else begin
                    r_vld[k+1] <= s_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k+1]  <= n_rem;
                r_dvd[k+1]  <= n_dvd;
                r_quo[k+1]  <= n_quo;
                r_den[k+1]  <= s_den[k];
                r_side[k+1] <= s_side[k];
            end

            assign s_vld[k+1]  = r_vld[k+1];
            assign s_rem[k+1]  = r_rem[k+1];
            assign s_dvd[k+1]  = r_dvd[k+1];
            assign s_quo[k+1]  = r_quo[k+1];
            assign s_den[k+1]  = r_den[k+1];
            assign s_side[k+1] = r_side[k+1];
        end
    endgenerate

    assign sq = s_quo[NST] * s_quo[NST];

    always_comb begin
        n_sq_side    = s_side[NST];
        n_sq_side.a  = s_quo[NST];
        n_sq_side.s2 = sq[58:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else begin
            r_sq_vld <= s_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_side <= n_sq_side;
    end

    // the final remainder is not needed
    logic unused_rem;
    assign unused_rem = ^s_rem[NST] ^ ^s_dvd[NST] ^ sq[59] ^ ^sq[29:0];

    assign o_valid = r_sq_vld;
    assign o_side  = r_sq_side;

endmodule

// ===== rtl/csqt_hstep.sv =====
// One Horner step p' = K + trunc(p * x / 2^30) over two stages:
// split partial products, then sum, truncate toward zero and add.
// Depends on csqt_pkg.
`timescale 1ns / 1ps

module csqt_hstep #(
    parameter logic signed [35:0] K     = 36'sd0,
    parameter bit                 USE_A = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  csqt_pkg::t_side        i_side,
    input  logic signed [35:0]     i_p,
    output logic                   o_valid,
    output csqt_pkg::t_side        o_side,
    output logic signed [35:0]     o_p
);

    logic signed [30:0] x;
    logic signed [48:0] n_pl;
    logic signed [49:0] n_ph;
    logic signed [63:0] prod;
    logic signed [63:0] q;

    logic               r_v1;
    logic               r_v2;
    logic signed [48:0] r_pl;
    logic signed [49:0] r_ph;
    csqt_pkg::t_side    r_side1;
    csqt_pkg::t_side    r_side2;
    logic signed [35:0] r_p;

    assign x    = USE_A ? $signed({1'b0, i_side.a}) : $signed({2'b00, i_side.s2});
    assign n_pl = $signed({1'b0, i_p[16:0]}) * x;
    assign n_ph = $signed(i_p[35:17]) * x;

    assign prod = (64'(r_ph) <<< 17) + 64'(r_pl);
    assign q    = prod[63] ? ((prod + 64'sd1073741823) >>> 30) : (prod >>> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl    <= n_pl;
        r_ph    <= n_ph;
        r_side1 <= i_side;
        r_side2 <= r_side1;
        r_p     <= K + 36'(q);
    end

    assign o_valid = r_v2;
    assign o_side  = r_side2;
    assign o_p     = r_p;

endmodule

// ===== rtl/csqt_tail.sv =====
// Weight from the sine, weighted sample, optional prior and saturation.
// Three stages. Depends on csqt_pkg.
`timescale 1ns / 1ps

module csqt_tail (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  csqt_pkg::t_side       i_side,
    input  logic signed [35:0]    i_sn,
    input  logic                  i_accumulate,
    output logic                  o_valid,
    output csqt_pkg::t_out_item   o_item
);

    logic [30:0]        snc;
    logic [31:0]        t;
    logic [16:0]        wr;
    logic [16:0]        n_w;
    logic signed [41:0] n_prod;
    logic signed [25:0] val;
    logic signed [26:0] sum;
    logic signed [23:0] sat;
    csqt_pkg::t_out_item n_out;

    logic               r_v1, r_v2, r_v3;
    logic [16:0]        r_w1, r_w2;
    logic signed [23:0] r_smp1;
    logic signed [23:0] r_pri1, r_pri2;
    logic signed [41:0] r_prod;
    csqt_pkg::t_out_item r_out;

    always_comb begin
        if (i_sn < 36'sd0) begin
            snc = 31'd0;
        end else if (i_sn > 36'sd1073741824) begin
            snc = 31'h4000_0000;
        end else begin
            snc = i_sn[30:0];
        end
        if (i_side.neg) begin
            t = 32'h4000_4000 + {1'b0, snc};
        end else begin
            t = 32'h4000_4000 - {1'b0, snc};
        end
        wr = (t[31:15] > 17'd65536) ? 17'd65536 : t[31:15];
        unique case (i_side.kind)
            csqt_pkg::KIND_RAMP: n_w = wr;
            csqt_pkg::KIND_ONE:  n_w = 17'd65536;
            default:             n_w = 17'd0;
        endcase
    end

    assign n_prod = r_smp1 * $signed({1'b0, r_w1});

    // round half up, then add prior if enabled
    assign val = 26'((r_prod + 42'sd32768) >>> 16);
    assign sum = 27'(val) + (i_accumulate ? 27'(r_pri2) : 27'sd0);
    assign sat = (sum > 27'sd8388607)  ? 24'sh7FFFFF :
                 (sum < -27'sd8388608) ? 24'sh800000 : sum[23:0];

    always_comb begin
        n_out.result_value   = sat;
        n_out.weight_applied = r_w2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1   <= n_w;
        r_smp1 <= i_side.sample;
        r_pri1 <= i_side.prior;
        r_prod <= n_prod;
        r_w2   <= r_w1;
        r_pri2 <= r_pri1;
        r_out  <= n_out;
    end

    assign o_valid = r_v3;
    assign o_item  = r_out;

endmodule

// ===== rtl/cosine_squared_window_taper_top.sv =====
// Cosine-squared taper window, top level.
// Depends on csqt_pkg, csqt_regs, csqt_decode, csqt_div, csqt_hstep, csqt_tail.
//
// Use: an item (index, sample, prior) is transferred at a clock edge with
// start high and busy low. busy is always low, so an item may be issued in
// every cycle. Each item gives one result, shown on o_result for exactly one
// cycle with o_valid high; results leave in the order items came in.
// Throughput is one item per clock.
// Pipeline: one decode stage, five divider stages (eight quotient bits each),
// one squaring stage, six two-stage polynomial steps, three output stages.
// The receiver cannot stall; every result must be taken when shown.
// Ramp and accumulate registers are written over the APB port and should
// only change while no item is in flight.
// Reset (i_rst_n low, synchronous) clears the pipeline and loads the
// register defaults: ramps 0, 0, 1024, 1024 and accumulate off.
`timescale 1ns / 1ps

module cosine_squared_window_taper_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  csqt_pkg::t_in_item      i_item,
    output logic                    o_valid,
    output csqt_pkg::t_out_item     o_result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    csqt_pkg::t_cfg     cfg;
    logic               dec_v;
    csqt_pkg::t_side    dec_side;
    logic [10:0]        dec_mag;
    logic [10:0]        dec_den;
    logic               div_v;
    csqt_pkg::t_side    div_side;

    logic               h_v    [0:6];
    csqt_pkg::t_side    h_side [0:6];
    logic signed [35:0] h_p    [0:6];

    assign busy = 1'b0;

    csqt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    csqt_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_item  (i_item),
        .i_cfg   (cfg),
        .o_valid (dec_v),
        .o_side  (dec_side),
        .o_mag   (dec_mag),
        .o_den   (dec_den)
    );

    csqt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_v),
        .i_side  (dec_side),
        .i_mag   (dec_mag),
        .i_den   (dec_den),
        .o_valid (div_v),
        .o_side  (div_side)
    );

    assign h_v[0]    = div_v;
    assign h_side[0] = div_side;
    assign h_p[0]    = -csqt_pkg::K11;

    csqt_hstep #(.K(csqt_pkg::K9), .USE_A(1'b0)) u_h9 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (h_v[0]), .i_side (h_side[0]), .i_p (h_p[0]),
        .o_valid (h_v[1]), .o_side (h_side[1]), .o_p (h_p[1])
    );

    csqt_hstep #(.K(-csqt_pkg::K7), .USE_A(1'b0)) u_h7 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (h_v[1]), .i_side (h_side[1]), .i_p (h_p[1]),
        .o_valid (h_v[2]), .o_side (h_side[2]), .o_p (h_p[2])
    );

    csqt_hstep #(.K(csqt_pkg::K5), .USE_A(1'b0)) u_h5 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (h_v[2]), .i_side (h_side[2]), .i_p (h_p[2]),
        .o_valid (h_v[3]), .o_side (h_side[3]), .o_p (h_p[3])
    );

    csqt_hstep #(.K(-csqt_pkg::K3), .USE_A(1'b0)) u_h3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (h_v[3]), .i_side (h_side[3]), .i_p (h_p[3]),
        .o_valid (h_v[4]), .o_side (h_side[4]), .o_p (h_p[4])
    );

    csqt_hstep #(.K(csqt_pkg::K1), .USE_A(1'b0)) u_h1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (h_v[4]), .i_side (h_side[4]), .i_p (h_p[4]),
        .o_valid (h_v[5]), .o_side (h_side[5]), .o_p (h_p[5])
    );

    // last step multiplies by a itself: the sine
    csqt_hstep #(.K(36'sd0), .USE_A(1'b1)) u_hsin (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (h_v[5]), .i_side (h_side[5]), .i_p (h_p[5]),
        .o_valid (h_v[6]), .o_side (h_side[6]), .o_p (h_p[6])
    );

    csqt_tail u_tail (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (h_v[6]),
        .i_side       (h_side[6]),
        .i_sn         (h_p[6]),
        .i_accumulate (cfg.accumulate),
        .o_valid      (o_valid),
        .o_item       (o_result)
    );

endmodule
